>>> design/pafk_pkg.sv
// ----------------------------------------------------------------------------
// pafk_pkg
// Shared constants, types and table of the planar arm forward kinematics block
// ----------------------------------------------------------------------------
package pafk_pkg;

  localparam int MAX_JOINTS   = 64;
  localparam int CORDIC_STEPS = 16;

  // rotation steps actually run, the arctangent table holds 24
  localparam int STEPS   = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

  localparam int ANG_W   = 16;
  localparam int Q15_W   = 16;
  localparam int SUM_W   = 24;
  localparam int JU_W    = 7;
  localparam int VEC_W   = 34;                       // Q4.30 vector, residual angle at 2^32 units per turn
  localparam int TALLY_W = $clog2(MAX_JOINTS + 1);
  localparam int DIV_W   = SUM_W + 1;                // rounded magnitude
  localparam int REM_W   = TALLY_W + 1;
  localparam int DCNT_W  = $clog2(DIV_W);

  localparam logic signed [VEC_W-1:0] GAIN_Q30 = 34'sd652032875;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROT,
    ST_ACC,
    ST_DINIT,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic rot;
    logic accum;
    logic div_init;
    logic div_step;
    logic emit;
  } pafk_cmd_t;

  typedef struct packed {
    logic full;
    logic in_last;
    logic last;
    logic step_last;
    logic div_last;
    logic out_free;
  } pafk_sts_t;

  // arctangent of 2^-i, 2^32 units per turn
  function automatic logic signed [VEC_W-1:0] atan_f(input logic [4:0] idx);
    logic signed [VEC_W-1:0] v;
    case (idx)
      5'd0:    v = 34'sd536870912;
      5'd1:    v = 34'sd316933406;
      5'd2:    v = 34'sd167458907;
      5'd3:    v = 34'sd85004756;
      5'd4:    v = 34'sd42667331;
      5'd5:    v = 34'sd21354465;
      5'd6:    v = 34'sd10679838;
      5'd7:    v = 34'sd5340245;
      5'd8:    v = 34'sd2670163;
      5'd9:    v = 34'sd1335087;
      5'd10:   v = 34'sd667544;
      5'd11:   v = 34'sd333772;
      5'd12:   v = 34'sd166886;
      5'd13:   v = 34'sd83443;
      5'd14:   v = 34'sd41722;
      5'd15:   v = 34'sd20861;
      5'd16:   v = 34'sd10430;
      5'd17:   v = 34'sd5215;
      5'd18:   v = 34'sd2608;
      5'd19:   v = 34'sd1304;
      5'd20:   v = 34'sd652;
      5'd21:   v = 34'sd326;
      5'd22:   v = 34'sd163;
      5'd23:   v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> design/pafk_div.sv
// ----------------------------------------------------------------------------
// pafk_div
// One lane of the averaging divider: rounded signed sum / count, saturated
// ----------------------------------------------------------------------------
module pafk_div import pafk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    init,
  input  logic                    step,
  input  logic signed [SUM_W-1:0] sum,
  input  logic [TALLY_W-1:0]      n,
  output logic signed [Q15_W-1:0] quo,
  output logic                    last
);

  logic [DIV_W-1:0]  dq_r, dq_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [DIV_W-1:0]  mag;
  logic [REM_W:0]    trial;
  logic              qbit;

  // magnitude plus half the count gives round half away from zero
  assign mag   = sum[SUM_W-1] ? DIV_W'(-$signed({sum[SUM_W-1], sum})) : DIV_W'({1'b0, sum});
  assign trial = {rem_r, dq_r[DIV_W-1]};
  assign qbit  = (trial >= (REM_W+1)'(n));
  assign last  = (cnt_r == DCNT_W'(DIV_W - 1));

  always_comb begin
    dq_nxt  = dq_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    if (init) begin
      dq_nxt  = mag + DIV_W'(n >> 1);
      rem_nxt = '0;
      cnt_nxt = '0;
      neg_nxt = sum[SUM_W-1];
    end else if (step) begin
      dq_nxt  = {dq_r[DIV_W-2:0], qbit};
      rem_nxt = qbit ? REM_W'(trial - (REM_W+1)'(n)) : trial[REM_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  // sign back on and saturate to q1.15
  always_comb begin
    if (n == '0) begin
      quo = '0;
    end else if (neg_r) begin
      quo = (dq_r >= DIV_W'(32768)) ? 16'sh8000 : Q15_W'(-$signed({1'b0, dq_r}));
    end else begin
      quo = (dq_r > DIV_W'(32767)) ? 16'sh7fff : Q15_W'(dq_r);
    end
  end

endmodule

>>> design/pafk_datapath.sv
// ----------------------------------------------------------------------------
// pafk_datapath
// Angle sum, iterative cordic rotation, term sums, averaging and output register
// ----------------------------------------------------------------------------
module pafk_datapath import pafk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pafk_cmd_t         cmd,
  output pafk_sts_t         sts,
  input  logic [ANG_W-1:0]  in_tdata,
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata
);

  logic [ANG_W-1:0]          angle_total_r;
  logic signed [SUM_W-1:0]   sum_x_r, sum_y_r;
  logic [TALLY_W-1:0]        tally_r;
  logic                      last_r;
  logic                      flip_r;
  logic signed [VEC_W-1:0]   x_r, y_r, z_r;
  logic [STEP_W-1:0]         step_r;
  logic                      out_valid_r;
  logic signed [Q15_W-1:0]   out_x_r, out_y_r;
  logic [JU_W-1:0]           out_n_r;

  logic [ANG_W-1:0]          fold_ang;
  logic                      fold;
  logic signed [VEC_W-1:0]   dx, dy, atn;
  logic signed [Q15_W-1:0]   term_x, term_y;
  logic signed [Q15_W-1:0]   quo_x, quo_y;
  logic                      last_x, last_y;
  logic [31:0]               tally32;

  function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [VEC_W-1:0] v,
                                                     input logic flip);
    logic signed [VEC_W:0] r;
    r = ($signed({v[VEC_W-1], v}) + 35'sd16384) >>> 15;
    if (flip) r = -r;
    if (r > 35'sd32767) return 16'sh7fff;
    if (r < -35'sd32768) return 16'sh8000;
    return Q15_W'(r);
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [Q15_W-1:0] t);
    logic signed [SUM_W:0] r;
    r = $signed({s[SUM_W-1], s}) + (SUM_W+1)'(t);
    if (r[SUM_W] != r[SUM_W-1]) return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                : {1'b0, {(SUM_W-1){1'b1}}};
    return r[SUM_W-1:0];
  endfunction

  // fold into a quarter turn either side of zero; a half turn flips bit 15
  assign fold     = angle_total_r[ANG_W-1] ^ angle_total_r[ANG_W-2];
  assign fold_ang = {angle_total_r[ANG_W-1] ^ fold, angle_total_r[ANG_W-2:0]};

  assign dx  = y_r >>> step_r;
  assign dy  = x_r >>> step_r;
  assign atn = atan_f(5'(step_r));

  assign term_x = to_q15(x_r, flip_r);
  assign term_y = to_q15(y_r, flip_r);

  assign tally32 = 32'(tally_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_total_r <= '0;
      sum_x_r       <= '0;
      sum_y_r       <= '0;
      tally_r       <= '0;
      step_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.accept && !sts.full) angle_total_r <= angle_total_r + in_tdata;
      if (cmd.load) step_r <= '0;
      else if (cmd.rot) step_r <= step_r + 1'b1;
      if (cmd.accum) begin
        sum_x_r <= sat_add(sum_x_r, term_x);
        sum_y_r <= sat_add(sum_y_r, term_y);
        tally_r <= tally_r + 1'b1;
      end
      if (cmd.emit) begin
        angle_total_r <= '0;
        sum_x_r       <= '0;
        sum_y_r       <= '0;
        tally_r       <= '0;
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) last_r <= in_tlast;
    if (cmd.load) begin
      flip_r <= fold;
      x_r    <= GAIN_Q30;
      y_r    <= '0;
      z_r    <= {{(VEC_W-ANG_W-16){fold_ang[ANG_W-1]}}, fold_ang, 16'b0};
    end else if (cmd.rot) begin
      if (!z_r[VEC_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atn;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atn;
      end
    end
    if (cmd.emit) begin
      out_x_r <= quo_x;
      out_y_r <= quo_y;
      out_n_r <= tally32[JU_W-1:0];
    end
  end

  pafk_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .init  (cmd.div_init),
    .step  (cmd.div_step),
    .sum   (sum_x_r),
    .n     (tally_r),
    .quo   (quo_x),
    .last  (last_x)
  );

  pafk_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .init  (cmd.div_init),
    .step  (cmd.div_step),
    .sum   (sum_y_r),
    .n     (tally_r),
    .quo   (quo_y),
    .last  (last_y)
  );

  always_comb begin
    sts.full      = (tally_r >= TALLY_W'(MAX_JOINTS));
    sts.in_last   = in_tlast;
    sts.last      = last_r;
    sts.step_last = (step_r == STEP_W'(STEPS - 1));
    sts.div_last  = last_x & last_y;
    sts.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_n_r, out_y_r, out_x_r};

  a_tally_max: assert property (@(posedge clk) disable iff (!rst_n)
    tally_r <= TALLY_W'(MAX_JOINTS))
    else $error("joint tally above limit");

  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r && tally_r == '0 && sum_x_r == '0 && angle_total_r == '0)
    else $error("state not cleared after result");

  a_acc_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accum |=> tally_r == $past(tally_r) + 1'b1)
    else $error("tally did not advance on accumulate");

endmodule

>>> design/pafk_ctrl.sv
// ----------------------------------------------------------------------------
// pafk_ctrl
// Sequencer: accept, rotate, accumulate, divide, hand off the result
// ----------------------------------------------------------------------------
module pafk_ctrl import pafk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  pafk_sts_t sts,
  output pafk_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (!sts.full) state_nxt = ST_LOAD;
          else if (sts.in_last) state_nxt = ST_DINIT;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        cmd.rot = 1'b1;
        if (sts.step_last) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = sts.last ? ST_DINIT : ST_IDLE;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_rot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROT && !sts.step_last |=> state_r == ST_ROT)
    else $error("rotation left early");

  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && sts.out_free |=> state_r == ST_IDLE)
    else $error("result handoff stuck");

  a_div_follow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |=> state_r == ST_DIV)
    else $error("divide did not start after init");

endmodule

>>> design/planar_arm_forward_kinematics.sv
// ----------------------------------------------------------------------------
// planar_arm_forward_kinematics
// End-effector position of an N-link planar arm from streamed joint angles
// ----------------------------------------------------------------------------
// usage
//   input stream: one joint angle per transfer, in_tlast on the final joint
//   of an arm; angles are binary angle units, 65536 per turn
//   output stream: one transfer per arm carrying end x, end y (q1.15, total
//   arm length one) and the number of joints used
//   each joint goes through the accept, a load, the cordic steps of the
//   single shift-add rotator and an accumulate before the input is
//   ready again
//   the final joint then runs the bit-serial divider that averages both
//   sums over the joint count, then the result enters the output register
//   joints past MAX_JOINTS are taken and leave the sums and tally alone
//   reset (synchronous, rst_n low) clears the sums, tally and output valid
//   a stalled receiver holds the result in the output register; the next arm
//   is still taken and worked on, and only its own handoff waits
// ----------------------------------------------------------------------------
module planar_arm_forward_kinematics import pafk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [ANG_W-1:0]  in_tdata,   // [15:0] joint_angle
  input  logic              in_tlast,   // last_joint
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata   // [15:0] end_x, [31:16] end_y, [38:32] joints_used
);

  pafk_cmd_t cmd;
  pafk_sts_t sts;

  // sequencer
  pafk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // rotator, sums, divider and output register
  pafk_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
